@@ sv/source_text_lexer_core_macros.svh @@
// ----------------------------------------------------------------------------
// source text lexer assertion macros
// concurrent assertion helpers shared by the lexer rtl; compiled out
// when NO_ASSERTIONS is defined
// ----------------------------------------------------------------------------
`ifndef SOURCE_TEXT_LEXER_CORE_MACROS_SVH
`define SOURCE_TEXT_LEXER_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define STL_ASSERT_IMP(lbl, clk_i, rst_ni, pre, post, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
		else $error(msg);

// next-cycle implication
`define STL_ASSERT_NXT(lbl, clk_i, rst_ni, pre, post, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
		else $error(msg);

`else

`define STL_ASSERT_IMP(lbl, clk_i, rst_ni, pre, post, msg)
`define STL_ASSERT_NXT(lbl, clk_i, rst_ni, pre, post, msg)

`endif

`endif

@@ sv/stl_pkg.sv @@
// ----------------------------------------------------------------------------
// stl_pkg
// shared types, character codes and helpers of the source text lexer
// ----------------------------------------------------------------------------
package stl_pkg;

	localparam int OFFSET_BITS_DEF = 32;
	localparam int LINE_BITS_DEF   = 16;
	localparam int NEST_BITS_DEF   = 8;
	localparam int MAX_RESULTS     = 4;
	localparam int RES_SLOTS       = 6;

	typedef enum logic [4:0] {
		K_LPAREN      = 5'd0,
		K_RPAREN      = 5'd1,
		K_LBRACE      = 5'd2,
		K_RBRACE      = 5'd3,
		K_COMMA       = 5'd4,
		K_DOT         = 5'd5,
		K_MINUS       = 5'd6,
		K_PLUS        = 5'd7,
		K_SEMI        = 5'd8,
		K_STAR        = 5'd9,
		K_BANG        = 5'd10,
		K_EQUAL       = 5'd11,
		K_POWER       = 5'd12,
		K_MOD         = 5'd13,
		K_ASSIGN      = 5'd14,
		K_LESS        = 5'd15,
		K_LESS_EQ     = 5'd16,
		K_GREATER     = 5'd17,
		K_GREATER_EQ  = 5'd18,
		K_NOT_EQ      = 5'd19,
		K_SLASH       = 5'd20,
		K_STRING      = 5'd21,
		K_NUMBER      = 5'd22,
		K_IDENT       = 5'd23,
		K_EOF         = 5'd24,
		K_ERR_CHAR    = 5'd25,
		K_ERR_STRING  = 5'd26,
		K_ERR_COMMENT = 5'd27
	} kind_t;

	typedef enum logic [11:0] {
		MODE_IDLE    = 12'h001,
		MODE_COLON   = 12'h002,
		MODE_LESS    = 12'h004,
		MODE_GREATER = 12'h008,
		MODE_SLASH   = 12'h010,
		MODE_LINEC   = 12'h020,
		MODE_BLOCK   = 12'h040,
		MODE_STRING  = 12'h080,
		MODE_NUM     = 12'h100,
		MODE_NUMDOT  = 12'h200,
		MODE_FRAC    = 12'h400,
		MODE_IDENT   = 12'h800
	} mode_t;

	typedef enum logic [1:0] {
		PREV_NONE  = 2'd0,
		PREV_SLASH = 2'd1,
		PREV_STAR  = 2'd2
	} prev_t;

	typedef struct packed {
		kind_t       kind;
		logic [31:0] start;
		logic [15:0] len;
		logic [15:0] line;
		logic [7:0]  ech;
	} token_t;

	localparam logic [7:0] CH_LPAREN     = 8'h28;
	localparam logic [7:0] CH_RPAREN     = 8'h29;
	localparam logic [7:0] CH_LBRACE     = 8'h7B;
	localparam logic [7:0] CH_RBRACE     = 8'h7D;
	localparam logic [7:0] CH_COMMA      = 8'h2C;
	localparam logic [7:0] CH_DOT        = 8'h2E;
	localparam logic [7:0] CH_MINUS      = 8'h2D;
	localparam logic [7:0] CH_PLUS       = 8'h2B;
	localparam logic [7:0] CH_SEMI       = 8'h3B;
	localparam logic [7:0] CH_STAR       = 8'h2A;
	localparam logic [7:0] CH_BANG       = 8'h21;
	localparam logic [7:0] CH_EQUAL      = 8'h3D;
	localparam logic [7:0] CH_CARET      = 8'h5E;
	localparam logic [7:0] CH_PERCENT    = 8'h25;
	localparam logic [7:0] CH_COLON      = 8'h3A;
	localparam logic [7:0] CH_LESS       = 8'h3C;
	localparam logic [7:0] CH_GREATER    = 8'h3E;
	localparam logic [7:0] CH_SLASH      = 8'h2F;
	localparam logic [7:0] CH_QUOTE      = 8'h22;
	localparam logic [7:0] CH_SPACE      = 8'h20;
	localparam logic [7:0] CH_CR         = 8'h0D;
	localparam logic [7:0] CH_TAB        = 8'h09;
	localparam logic [7:0] CH_NL         = 8'h0A;
	localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
	localparam logic [7:0] CH_0          = 8'h30;
	localparam logic [7:0] CH_9          = 8'h39;
	localparam logic [7:0] CH_LA         = 8'h61;
	localparam logic [7:0] CH_LZ         = 8'h7A;
	localparam logic [7:0] CH_UA         = 8'h41;
	localparam logic [7:0] CH_UZ         = 8'h5A;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_0) && (c <= CH_9);
	endfunction

	function automatic logic is_word(input logic [7:0] c);
		return ((c >= CH_LA) && (c <= CH_LZ)) || ((c >= CH_UA) && (c <= CH_UZ)) ||
			(c == CH_UNDERSCORE) || is_digit(c);
	endfunction

	function automatic token_t mk_token(input kind_t k, input logic [31:0] st,
		input logic [15:0] ln, input logic [15:0] li, input logic [7:0] e);
		token_t t;
		t.kind  = k;
		t.start = st;
		t.len   = ln;
		t.line  = li;
		t.ech   = e;
		return t;
	endfunction

endpackage

@@ sv/stl_scan.sv @@
// ----------------------------------------------------------------------------
// stl_scan
// next-state and token logic for one source byte and/or end mark
// ----------------------------------------------------------------------------
module stl_scan #(
	parameter int OFFSET_BITS = stl_pkg::OFFSET_BITS_DEF,
	parameter int LINE_BITS   = stl_pkg::LINE_BITS_DEF,
	parameter int NEST_BITS   = stl_pkg::NEST_BITS_DEF
) (
	input  logic [7:0]             char_code,
	input  logic                   char_present,
	input  logic                   end_of_source,
	input  stl_pkg::mode_t         mode,
	input  stl_pkg::prev_t         prev,
	input  logic [NEST_BITS-1:0]   depth,
	input  logic [OFFSET_BITS-1:0] pos,
	input  logic [OFFSET_BITS-1:0] tstart,
	input  logic [LINE_BITS-1:0]   line,
	output stl_pkg::mode_t         mode_nxt,
	output stl_pkg::prev_t         prev_nxt,
	output logic [NEST_BITS-1:0]   depth_nxt,
	output logic [OFFSET_BITS-1:0] pos_nxt,
	output logic [OFFSET_BITS-1:0] tstart_nxt,
	output logic [LINE_BITS-1:0]   line_nxt,
	output stl_pkg::token_t        res [stl_pkg::MAX_RESULTS],
	output logic [2:0]             res_cnt
);

	function automatic logic [15:0] span_len(input logic [OFFSET_BITS-1:0] e,
		input logic [OFFSET_BITS-1:0] s);
		logic [OFFSET_BITS-1:0] d;
		d = e - s;
		if (e <= s)
			return 16'd0;
		return (64'(d) > 64'hFFFF) ? 16'hFFFF : 16'(d);
	endfunction

	// classification of a byte seen with nothing pending
	logic           idle_emit;
	stl_pkg::kind_t idle_kind;
	logic [7:0]     idle_ech;
	stl_pkg::mode_t idle_mode;
	logic           idle_setts;
	logic           idle_nl;

	always_comb begin
		idle_emit  = 1'b0;
		idle_kind  = stl_pkg::K_ERR_CHAR;
		idle_ech   = 8'd0;
		idle_mode  = stl_pkg::MODE_IDLE;
		idle_setts = 1'b0;
		idle_nl    = 1'b0;
		case (char_code)
			stl_pkg::CH_LPAREN: begin idle_emit = 1'b1; idle_kind = stl_pkg::K_LPAREN; end
			stl_pkg::CH_RPAREN: begin idle_emit = 1'b1; idle_kind = stl_pkg::K_RPAREN; end
			stl_pkg::CH_LBRACE: begin idle_emit = 1'b1; idle_kind = stl_pkg::K_LBRACE; end
			stl_pkg::CH_RBRACE: begin idle_emit = 1'b1; idle_kind = stl_pkg::K_RBRACE; end
			stl_pkg::CH_COMMA: begin idle_emit = 1'b1; idle_kind = stl_pkg::K_COMMA; end
			stl_pkg::CH_DOT: begin idle_emit = 1'b1; idle_kind = stl_pkg::K_DOT; end
			stl_pkg::CH_MINUS: begin idle_emit = 1'b1; idle_kind = stl_pkg::K_MINUS; end
			stl_pkg::CH_PLUS: begin idle_emit = 1'b1; idle_kind = stl_pkg::K_PLUS; end
			stl_pkg::CH_SEMI: begin idle_emit = 1'b1; idle_kind = stl_pkg::K_SEMI; end
			stl_pkg::CH_STAR: begin idle_emit = 1'b1; idle_kind = stl_pkg::K_STAR; end
			stl_pkg::CH_BANG: begin idle_emit = 1'b1; idle_kind = stl_pkg::K_BANG; end
			stl_pkg::CH_EQUAL: begin idle_emit = 1'b1; idle_kind = stl_pkg::K_EQUAL; end
			stl_pkg::CH_CARET: begin idle_emit = 1'b1; idle_kind = stl_pkg::K_POWER; end
			stl_pkg::CH_PERCENT: begin idle_emit = 1'b1; idle_kind = stl_pkg::K_MOD; end
			stl_pkg::CH_COLON: begin idle_mode = stl_pkg::MODE_COLON; idle_setts = 1'b1; end
			stl_pkg::CH_LESS: begin idle_mode = stl_pkg::MODE_LESS; idle_setts = 1'b1; end
			stl_pkg::CH_GREATER: begin idle_mode = stl_pkg::MODE_GREATER; idle_setts = 1'b1; end
			stl_pkg::CH_SLASH: begin idle_mode = stl_pkg::MODE_SLASH; idle_setts = 1'b1; end
			stl_pkg::CH_QUOTE: begin idle_mode = stl_pkg::MODE_STRING; idle_setts = 1'b1; end
			stl_pkg::CH_SPACE, stl_pkg::CH_CR, stl_pkg::CH_TAB: begin
				idle_emit = 1'b0;
			end
			stl_pkg::CH_NL: begin idle_nl = 1'b1; end
			default: begin
				if (stl_pkg::is_digit(char_code)) begin
					idle_mode  = stl_pkg::MODE_NUM;
					idle_setts = 1'b1;
				end else if (stl_pkg::is_word(char_code)) begin
					idle_mode  = stl_pkg::MODE_IDENT;
					idle_setts = 1'b1;
				end else begin
					idle_emit = 1'b1;
					idle_kind = stl_pkg::K_ERR_CHAR;
					idle_ech  = char_code;
				end
			end
		endcase
	end

	stl_pkg::mode_t         mode_a;
	stl_pkg::prev_t         prev_a;
	logic [NEST_BITS-1:0]   depth_a;
	logic [NEST_BITS-1:0]   depth_dec;
	logic [OFFSET_BITS-1:0] ts_a;
	logic [OFFSET_BITS-1:0] pos_a;
	logic [OFFSET_BITS-1:0] pos_inc;
	logic [OFFSET_BITS-1:0] dot_pos;
	logic [OFFSET_BITS-1:0] fin_dot;
	logic [LINE_BITS-1:0]   line_a;
	logic [LINE_BITS-1:0]   line_inc;
	logic                   do_idle;
	logic                   is_eq;
	stl_pkg::token_t        slot [stl_pkg::RES_SLOTS];
	logic [stl_pkg::RES_SLOTS-1:0] slot_v;
	logic [15:0]            ln_old;
	logic [15:0]            ln_new;

	assign pos_inc   = (&pos) ? pos : pos + 1'b1;
	assign line_inc  = (&line) ? line : line + 1'b1;
	assign depth_dec = (depth != '0) ? depth - 1'b1 : depth;
	assign dot_pos   = (pos > tstart) ? pos - 1'b1 : pos;
	assign is_eq     = (char_code == stl_pkg::CH_EQUAL);
	assign ln_old    = 16'(line);

	always_comb begin
		mode_a  = mode;
		prev_a  = prev;
		depth_a = depth;
		ts_a    = tstart;
		line_a  = line;
		pos_a   = char_present ? pos_inc : pos;
		do_idle = 1'b0;
		slot_v  = '0;
		for (int i = 0; i < stl_pkg::RES_SLOTS; i++)
			slot[i] = '0;

		if (char_present) begin
			case (mode)
				stl_pkg::MODE_COLON: begin
					if (is_eq) begin
						slot[0]   = stl_pkg::mk_token(stl_pkg::K_ASSIGN, 32'(tstart), 16'd2, ln_old,
							8'd0);
						slot_v[0] = 1'b1;
						mode_a    = stl_pkg::MODE_IDLE;
					end else
						do_idle = 1'b1;
				end
				stl_pkg::MODE_LESS, stl_pkg::MODE_GREATER: begin
					slot_v[0] = 1'b1;
					if (is_eq) begin
						slot[0] = stl_pkg::mk_token((mode == stl_pkg::MODE_LESS) ?
							stl_pkg::K_LESS_EQ : stl_pkg::K_GREATER_EQ, 32'(tstart), 16'd2, ln_old,
							8'd0);
						mode_a  = stl_pkg::MODE_IDLE;
					end else begin
						slot[0] = stl_pkg::mk_token((mode == stl_pkg::MODE_LESS) ?
							stl_pkg::K_LESS : stl_pkg::K_GREATER, 32'(tstart), 16'd1, ln_old, 8'd0);
						do_idle = 1'b1;
					end
				end
				stl_pkg::MODE_SLASH: begin
					if (is_eq) begin
						slot[0]   = stl_pkg::mk_token(stl_pkg::K_NOT_EQ, 32'(tstart), 16'd2, ln_old,
							8'd0);
						slot_v[0] = 1'b1;
						mode_a    = stl_pkg::MODE_IDLE;
					end else if (char_code == stl_pkg::CH_SLASH) begin
						mode_a = stl_pkg::MODE_LINEC;
					end else if (char_code == stl_pkg::CH_STAR) begin
						mode_a  = stl_pkg::MODE_BLOCK;
						depth_a = NEST_BITS'(1);
						prev_a  = stl_pkg::PREV_NONE;
					end else begin
						slot[0]   = stl_pkg::mk_token(stl_pkg::K_SLASH, 32'(tstart), 16'd1, ln_old,
							8'd0);
						slot_v[0] = 1'b1;
						do_idle   = 1'b1;
					end
				end
				stl_pkg::MODE_LINEC: begin
					if (char_code == stl_pkg::CH_NL)
						do_idle = 1'b1;
				end
				stl_pkg::MODE_BLOCK: begin
					if (prev == stl_pkg::PREV_SLASH && char_code == stl_pkg::CH_STAR) begin
						if (!(&depth))
							depth_a = depth + 1'b1;
						prev_a = stl_pkg::PREV_NONE;
					end else if (prev == stl_pkg::PREV_STAR && char_code == stl_pkg::CH_SLASH) begin
						prev_a  = stl_pkg::PREV_NONE;
						depth_a = depth_dec;
						if (depth_dec == '0)
							mode_a = stl_pkg::MODE_IDLE;
					end else begin
						prev_a = (char_code == stl_pkg::CH_SLASH) ? stl_pkg::PREV_SLASH :
							(char_code == stl_pkg::CH_STAR) ? stl_pkg::PREV_STAR : stl_pkg::PREV_NONE;
						if (char_code == stl_pkg::CH_NL)
							line_a = line_inc;
					end
				end
				stl_pkg::MODE_STRING: begin
					if (char_code == stl_pkg::CH_QUOTE) begin
						slot[0]   = stl_pkg::mk_token(stl_pkg::K_STRING, 32'(tstart),
							span_len(pos_inc, tstart), ln_old, 8'd0);
						slot_v[0] = 1'b1;
						mode_a    = stl_pkg::MODE_IDLE;
					end else if (char_code == stl_pkg::CH_NL)
						line_a = line_inc;
				end
				stl_pkg::MODE_NUM: begin
					if (char_code == stl_pkg::CH_DOT)
						mode_a = stl_pkg::MODE_NUMDOT;
					else if (!stl_pkg::is_digit(char_code)) begin
						slot[0]   = stl_pkg::mk_token(stl_pkg::K_NUMBER, 32'(tstart),
							span_len(pos, tstart), ln_old, 8'd0);
						slot_v[0] = 1'b1;
						do_idle   = 1'b1;
					end
				end
				stl_pkg::MODE_NUMDOT: begin
					if (stl_pkg::is_digit(char_code))
						mode_a = stl_pkg::MODE_FRAC;
					else begin
						// number without fraction, then the dot on its own
						slot[0]   = stl_pkg::mk_token(stl_pkg::K_NUMBER, 32'(tstart),
							span_len(dot_pos, tstart), ln_old, 8'd0);
						slot[1]   = stl_pkg::mk_token(stl_pkg::K_DOT, 32'(dot_pos), 16'd1, ln_old,
							8'd0);
						slot_v[1:0] = 2'b11;
						do_idle     = 1'b1;
					end
				end
				stl_pkg::MODE_FRAC, stl_pkg::MODE_IDENT: begin
					if ((mode == stl_pkg::MODE_FRAC) ? !stl_pkg::is_digit(char_code) :
						!stl_pkg::is_word(char_code)) begin
						slot[0]   = stl_pkg::mk_token((mode == stl_pkg::MODE_FRAC) ?
							stl_pkg::K_NUMBER : stl_pkg::K_IDENT, 32'(tstart),
							span_len(pos, tstart), ln_old, 8'd0);
						slot_v[0] = 1'b1;
						do_idle   = 1'b1;
					end
				end
				default: begin
					do_idle = 1'b1;
				end
			endcase
		end

		if (do_idle) begin
			mode_a = idle_mode;
			if (idle_setts)
				ts_a = pos;
			if (idle_nl)
				line_a = line_inc;
			if (idle_emit) begin
				slot[2]   = stl_pkg::mk_token(idle_kind, 32'(pos), 16'd1, ln_old, idle_ech);
				slot_v[2] = 1'b1;
			end
		end
	end

	assign ln_new  = 16'(line_a);
	assign fin_dot = (pos_a > ts_a) ? pos_a - 1'b1 : pos_a;

	// close the open lexeme at end of source, then reset the scanner
	stl_pkg::token_t        fin [3];
	logic [2:0]             fin_v;

	always_comb begin
		fin_v  = 3'b000;
		fin[0] = '0;
		fin[1] = '0;
		fin[2] = stl_pkg::mk_token(stl_pkg::K_EOF, 32'(pos_a), 16'd0, ln_new, 8'd0);
		if (end_of_source) begin
			fin_v[2] = 1'b1;
			case (mode_a)
				stl_pkg::MODE_LESS: begin
					fin[0] = stl_pkg::mk_token(stl_pkg::K_LESS, 32'(ts_a), 16'd1, ln_new, 8'd0);
					fin_v[0] = 1'b1;
				end
				stl_pkg::MODE_GREATER: begin
					fin[0] = stl_pkg::mk_token(stl_pkg::K_GREATER, 32'(ts_a), 16'd1, ln_new, 8'd0);
					fin_v[0] = 1'b1;
				end
				stl_pkg::MODE_SLASH: begin
					fin[0] = stl_pkg::mk_token(stl_pkg::K_SLASH, 32'(ts_a), 16'd1, ln_new, 8'd0);
					fin_v[0] = 1'b1;
				end
				stl_pkg::MODE_BLOCK: begin
					fin[0] = stl_pkg::mk_token(stl_pkg::K_ERR_COMMENT, 32'(ts_a),
						span_len(pos_a, ts_a), ln_new, 8'd0);
					fin_v[0] = 1'b1;
				end
				stl_pkg::MODE_STRING: begin
					fin[0] = stl_pkg::mk_token(stl_pkg::K_ERR_STRING, 32'(ts_a),
						span_len(pos_a, ts_a), ln_new, 8'd0);
					fin_v[0] = 1'b1;
				end
				stl_pkg::MODE_NUM, stl_pkg::MODE_FRAC: begin
					fin[0] = stl_pkg::mk_token(stl_pkg::K_NUMBER, 32'(ts_a),
						span_len(pos_a, ts_a), ln_new, 8'd0);
					fin_v[0] = 1'b1;
				end
				stl_pkg::MODE_NUMDOT: begin
					fin[0] = stl_pkg::mk_token(stl_pkg::K_NUMBER, 32'(ts_a),
						span_len(fin_dot, ts_a), ln_new, 8'd0);
					fin[1] = stl_pkg::mk_token(stl_pkg::K_DOT, 32'(fin_dot), 16'd1, ln_new, 8'd0);
					fin_v[1:0] = 2'b11;
				end
				stl_pkg::MODE_IDENT: begin
					fin[0] = stl_pkg::mk_token(stl_pkg::K_IDENT, 32'(ts_a),
						span_len(pos_a, ts_a), ln_new, 8'd0);
					fin_v[0] = 1'b1;
				end
				default: begin
					fin_v[1:0] = 2'b00;
				end
			endcase
		end
	end

	// pack the valid slots in order, keeping the first four
	logic [2:0] k;

	always_comb begin
		stl_pkg::token_t all [stl_pkg::RES_SLOTS];
		logic [stl_pkg::RES_SLOTS-1:0] all_v;
		k = 3'd0;
		for (int j = 0; j < stl_pkg::MAX_RESULTS; j++)
			res[j] = '0;
		for (int i = 0; i < 3; i++) begin
			all[i]       = slot[i];
			all_v[i]     = slot_v[i];
			all[i + 3]   = fin[i];
			all_v[i + 3] = fin_v[i];
		end
		for (int i = 0; i < stl_pkg::RES_SLOTS; i++) begin
			if (all_v[i] && k < 3'(stl_pkg::MAX_RESULTS)) begin
				res[k[1:0]] = all[i];
				k = k + 3'd1;
			end
		end
	end

	assign res_cnt = k;

	always_comb begin
		if (end_of_source) begin
			mode_nxt   = stl_pkg::MODE_IDLE;
			prev_nxt   = stl_pkg::PREV_NONE;
			depth_nxt  = '0;
			pos_nxt    = '0;
			tstart_nxt = '0;
			line_nxt   = LINE_BITS'(1);
		end else begin
			mode_nxt   = mode_a;
			prev_nxt   = prev_a;
			depth_nxt  = depth_a;
			pos_nxt    = pos_a;
			tstart_nxt = ts_a;
			line_nxt   = line_a;
		end
	end

endmodule

@@ sv/source_text_lexer_core.sv @@
// ----------------------------------------------------------------------------
// source_text_lexer_core
// streaming lexical scanner: source bytes in, tokens out
// ----------------------------------------------------------------------------
// a byte waits in the input register stage, then its token words load the output buffer
// throughput: one byte per cycle unless a byte waits on the buffer; after a byte that
//   causes n tokens, the next byte that causes tokens waits until those n words have
//   left; the single-read output buffer drains one word per cycle while m_tready is high
// reset: arst_n clears the scanner state to idle, offset 0, line 1, and empties both stages

`include "source_text_lexer_core_macros.svh"

module source_text_lexer_core #(
	parameter int OFFSET_BITS = stl_pkg::OFFSET_BITS_DEF,
	parameter int LINE_BITS   = stl_pkg::LINE_BITS_DEF,
	parameter int NEST_BITS   = stl_pkg::NEST_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// source byte stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] char_code
	input  logic [0:0]  s_tuser,   // [0] char_present
	input  logic        s_tlast,   // end_of_source
	// token stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,   // [31:0] start_offset, [47:32] lexeme_length,
	                               // [63:48] line_number, [71:64] error_char
	output logic [4:0]  m_tuser,   // [4:0] token_kind
	output logic        m_tlast    // last_of_run
);

	// ------------------------------------------------------------------
	// input register stage
	// ------------------------------------------------------------------
	logic       valid_s1;
	logic [7:0] char_s1;
	logic       present_s1;
	logic       eos_s1;

	// ------------------------------------------------------------------
	// scanner state
	// ------------------------------------------------------------------
	stl_pkg::mode_t         mode_q;
	stl_pkg::prev_t         prev_q;
	logic [NEST_BITS-1:0]   depth_q;
	logic [OFFSET_BITS-1:0] pos_q;
	logic [OFFSET_BITS-1:0] tstart_q;
	logic [LINE_BITS-1:0]   line_q;

	stl_pkg::mode_t         mode_nxt;
	stl_pkg::prev_t         prev_nxt;
	logic [NEST_BITS-1:0]   depth_nxt;
	logic [OFFSET_BITS-1:0] pos_nxt;
	logic [OFFSET_BITS-1:0] tstart_nxt;
	logic [LINE_BITS-1:0]   line_nxt;

	stl_pkg::token_t        res [stl_pkg::MAX_RESULTS];
	logic [2:0]             res_cnt;

	// ------------------------------------------------------------------
	// output buffer: up to four token words of one byte, read in order
	// ------------------------------------------------------------------
	stl_pkg::token_t        res_q [stl_pkg::MAX_RESULTS];
	logic [2:0]             rem_q;   // words still to deliver
	logic [1:0]             rd_q;    // next word to deliver

	logic                   buf_free;
	logic                   commit;
	stl_pkg::token_t        cur;

	stl_scan #(
		.OFFSET_BITS (OFFSET_BITS),
		.LINE_BITS   (LINE_BITS),
		.NEST_BITS   (NEST_BITS)
	) u_scan (
		.char_code     (char_s1),
		.char_present  (present_s1),
		.end_of_source (eos_s1),
		.mode          (mode_q),
		.prev          (prev_q),
		.depth         (depth_q),
		.pos           (pos_q),
		.tstart        (tstart_q),
		.line          (line_q),
		.mode_nxt      (mode_nxt),
		.prev_nxt      (prev_nxt),
		.depth_nxt     (depth_nxt),
		.pos_nxt       (pos_nxt),
		.tstart_nxt    (tstart_nxt),
		.line_nxt      (line_nxt),
		.res           (res),
		.res_cnt       (res_cnt)
	);

	// buffer can take a new run when empty or when its last word leaves now
	assign buf_free = (rem_q == 3'd0) || (rem_q == 3'd1 && m_tready);
	// a byte with no tokens never waits on the buffer
	assign commit   = valid_s1 && (res_cnt == 3'd0 || buf_free);
	assign s_tready = !valid_s1 || commit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (commit) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			char_s1    <= s_tdata;
			present_s1 <= s_tuser[0];
			eos_s1     <= s_tlast;
		end
	end

	// scanner state advances once per committed byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= stl_pkg::MODE_IDLE;
			prev_q   <= stl_pkg::PREV_NONE;
			depth_q  <= '0;
			pos_q    <= '0;
			tstart_q <= '0;
			line_q   <= LINE_BITS'(1);
		end else if (commit) begin
			mode_q   <= mode_nxt;
			prev_q   <= prev_nxt;
			depth_q  <= depth_nxt;
			pos_q    <= pos_nxt;
			tstart_q <= tstart_nxt;
			line_q   <= line_nxt;
		end
	end

	// buffer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= 3'd0;
			rd_q  <= 2'd0;
		end else if (commit && res_cnt != 3'd0) begin
			rem_q <= res_cnt;
			rd_q  <= 2'd0;
		end else if (m_tvalid && m_tready) begin
			rem_q <= rem_q - 3'd1;
			rd_q  <= rd_q + 2'd1;
		end
	end

	// buffer payload
	always_ff @(posedge clk) begin
		if (commit && res_cnt != 3'd0) begin
			for (int i = 0; i < stl_pkg::MAX_RESULTS; i++)
				res_q[i] <= res[i];
		end
	end

	assign cur      = res_q[rd_q];
	assign m_tvalid = (rem_q != 3'd0);
	assign m_tdata  = {cur.ech, cur.line, cur.len, cur.start};
	assign m_tuser  = cur.kind;
	assign m_tlast  = (rem_q == 3'd1);

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------
	`STL_ASSERT_IMP(a_rem_bound, clk, arst_n, 1'b1, rem_q <= 3'd4,
		"output buffer holds more than four words")
	`STL_ASSERT_NXT(a_stall_hold, clk, arst_n, m_tvalid && !m_tready,
		rem_q == $past(rem_q) && rd_q == $past(rd_q), "buffer moved while output stalled")
	`STL_ASSERT_NXT(a_eos_reset, clk, arst_n, commit && eos_s1,
		mode_q == stl_pkg::MODE_IDLE && pos_q == '0 && m_tvalid,
		"end of source did not reset scanner or produce tokens")
	`STL_ASSERT_IMP(a_kind_range, clk, arst_n, m_tvalid, cur.kind <= stl_pkg::K_ERR_COMMENT,
		"token kind out of range")

endmodule

@@ test/stl_tb_pkg.sv @@
// ----------------------------------------------------------------------------
// lexer token scoreboard
// tracks the scanner state of the source text lexer, predicts the token
// words each accepted source word causes and checks them in order
// ----------------------------------------------------------------------------
package stl_tb_pkg;

	import stl_pkg::*;

	typedef struct packed {
		logic [7:0] code;
		logic       present;
		logic       eos;
	} src_item_t;

	typedef struct packed {
		kind_t       kind;
		logic [31:0] start;
		logic [15:0] len;
		logic [15:0] line;
		logic [7:0]  ech;
		logic        last;
	} token_word_t;

	localparam logic [7:0]  DEPTH_TOP  = 8'hFF;
	localparam logic [15:0] LINE_TOP   = 16'hFFFF;
	localparam logic [31:0] OFFSET_TOP = 32'hFFFF_FFFF;
	localparam logic [31:0] LEN_TOP    = 32'h0000_FFFF;
	localparam int          MAX_PRINTS = 30;

	class token_scoreboard;
		mode_t       mode;
		prev_t       prev;
		logic [7:0]  depth;
		logic [31:0] offset;
		logic [31:0] tok_start;
		logic [15:0] line_no;
		token_word_t run_words[$];
		token_word_t expected_tokens[$];
		int          errors;
		int          words_seen;

		function new();
			errors = 0;
			words_seen = 0;
			restart();
		endfunction

		function void restart();
			mode = MODE_IDLE;
			prev = PREV_NONE;
			depth = '0;
			offset = '0;
			tok_start = '0;
			line_no = 16'd1;
		endfunction

		function bit is_num_ch(logic [7:0] c);
			return c >= CH_0 && c <= CH_9;
		endfunction

		function bit is_name_ch(logic [7:0] c);
			return (c >= CH_LA && c <= CH_LZ) || (c >= CH_UA && c <= CH_UZ) ||
				c == CH_UNDERSCORE || is_num_ch(c);
		endfunction

		function void bump_line();
			if (line_no != LINE_TOP) line_no++;
		endfunction

		function logic [31:0] len_to(logic [31:0] stop);
			return (stop > tok_start) ? stop - tok_start : 32'd0;
		endfunction

		// at most four token words per source word
		function void emit_token(kind_t k, logic [31:0] st, logic [31:0] n, logic [7:0] ec);
			token_word_t w;
			if (run_words.size() >= MAX_RESULTS) return;
			w.kind = k;
			w.start = st;
			w.len = (n > LEN_TOP) ? 16'hFFFF : n[15:0];
			w.line = line_no;
			w.ech = ec;
			w.last = 1'b0;
			run_words.push_back(w);
		endfunction

		// a byte seen with nothing pending
		function void scan_fresh(logic [7:0] c, logic [31:0] p);
			kind_t k;
			bit    single;
			k = K_EOF;
			single = 1'b1;
			mode = MODE_IDLE;
			case (c)
				CH_LPAREN:  k = K_LPAREN;
				CH_RPAREN:  k = K_RPAREN;
				CH_LBRACE:  k = K_LBRACE;
				CH_RBRACE:  k = K_RBRACE;
				CH_COMMA:   k = K_COMMA;
				CH_DOT:     k = K_DOT;
				CH_MINUS:   k = K_MINUS;
				CH_PLUS:    k = K_PLUS;
				CH_SEMI:    k = K_SEMI;
				CH_STAR:    k = K_STAR;
				CH_BANG:    k = K_BANG;
				CH_EQUAL:   k = K_EQUAL;
				CH_CARET:   k = K_POWER;
				CH_PERCENT: k = K_MOD;
				CH_COLON: begin
					mode = MODE_COLON;
					single = 1'b0;
				end
				CH_LESS: begin
					mode = MODE_LESS;
					single = 1'b0;
				end
				CH_GREATER: begin
					mode = MODE_GREATER;
					single = 1'b0;
				end
				CH_SLASH: begin
					mode = MODE_SLASH;
					single = 1'b0;
				end
				CH_QUOTE: begin
					mode = MODE_STRING;
					single = 1'b0;
				end
				CH_SPACE, CH_CR, CH_TAB: return;
				CH_NL: begin
					bump_line();
					return;
				end
				default: begin
					if (is_num_ch(c)) mode = MODE_NUM;
					else if (is_name_ch(c)) mode = MODE_IDENT;
					else begin
						emit_token(K_ERR_CHAR, p, 32'd1, c);
						return;
					end
					single = 1'b0;
				end
			endcase
			if (single) emit_token(k, p, 32'd1, 8'd0);
			else tok_start = p;
		endfunction

		function void scan_byte(logic [7:0] c, logic [31:0] p);
			logic [31:0] nxt;
			logic [31:0] d;
			nxt = (p != OFFSET_TOP) ? p + 32'd1 : p;
			case (mode)
				MODE_COLON: begin
					if (c == CH_EQUAL) begin
						emit_token(K_ASSIGN, tok_start, 32'd2, 8'd0);
						mode = MODE_IDLE;
					end else scan_fresh(c, p);
				end
				MODE_LESS, MODE_GREATER: begin
					if (c == CH_EQUAL) begin
						emit_token((mode == MODE_LESS) ? K_LESS_EQ : K_GREATER_EQ, tok_start,
							32'd2, 8'd0);
						mode = MODE_IDLE;
					end else begin
						emit_token((mode == MODE_LESS) ? K_LESS : K_GREATER, tok_start,
							32'd1, 8'd0);
						scan_fresh(c, p);
					end
				end
				MODE_SLASH: begin
					if (c == CH_EQUAL) begin
						emit_token(K_NOT_EQ, tok_start, 32'd2, 8'd0);
						mode = MODE_IDLE;
					end else if (c == CH_SLASH) mode = MODE_LINEC;
					else if (c == CH_STAR) begin
						mode = MODE_BLOCK;
						depth = 8'd1;
						prev = PREV_NONE;
					end else begin
						emit_token(K_SLASH, tok_start, 32'd1, 8'd0);
						scan_fresh(c, p);
					end
				end
				MODE_LINEC: begin
					if (c == CH_NL) scan_fresh(c, p);
				end
				MODE_BLOCK: begin
					if (prev == PREV_SLASH && c == CH_STAR) begin
						if (depth != DEPTH_TOP) depth++;
						prev = PREV_NONE;
					end else if (prev == PREV_STAR && c == CH_SLASH) begin
						prev = PREV_NONE;
						if (depth != 0) depth--;
						if (depth == 0) mode = MODE_IDLE;
					end else begin
						prev = (c == CH_SLASH) ? PREV_SLASH : (c == CH_STAR) ? PREV_STAR : PREV_NONE;
						if (c == CH_NL) bump_line();
					end
				end
				MODE_STRING: begin
					if (c == CH_QUOTE) begin
						emit_token(K_STRING, tok_start, len_to(nxt), 8'd0);
						mode = MODE_IDLE;
					end else if (c == CH_NL) bump_line();
				end
				MODE_NUM: begin
					if (c == CH_DOT) mode = MODE_NUMDOT;
					else if (!is_num_ch(c)) begin
						emit_token(K_NUMBER, tok_start, len_to(p), 8'd0);
						scan_fresh(c, p);
					end
				end
				MODE_NUMDOT: begin
					if (is_num_ch(c)) mode = MODE_FRAC;
					else begin
						// the number ends before the dot, the dot is its own token
						d = (p > tok_start) ? p - 32'd1 : p;
						emit_token(K_NUMBER, tok_start, len_to(d), 8'd0);
						emit_token(K_DOT, d, 32'd1, 8'd0);
						scan_fresh(c, p);
					end
				end
				MODE_FRAC: begin
					if (!is_num_ch(c)) begin
						emit_token(K_NUMBER, tok_start, len_to(p), 8'd0);
						scan_fresh(c, p);
					end
				end
				MODE_IDENT: begin
					if (!is_name_ch(c)) begin
						emit_token(K_IDENT, tok_start, len_to(p), 8'd0);
						scan_fresh(c, p);
					end
				end
				default: scan_fresh(c, p);
			endcase
		endfunction

		// flush whatever is pending, then the end of file token
		function void finish_source();
			logic [31:0] d;
			case (mode)
				MODE_LESS:    emit_token(K_LESS, tok_start, 32'd1, 8'd0);
				MODE_GREATER: emit_token(K_GREATER, tok_start, 32'd1, 8'd0);
				MODE_SLASH:   emit_token(K_SLASH, tok_start, 32'd1, 8'd0);
				MODE_BLOCK:   emit_token(K_ERR_COMMENT, tok_start, len_to(offset), 8'd0);
				MODE_STRING:  emit_token(K_ERR_STRING, tok_start, len_to(offset), 8'd0);
				MODE_NUM, MODE_FRAC: emit_token(K_NUMBER, tok_start, len_to(offset), 8'd0);
				MODE_NUMDOT: begin
					d = (offset > tok_start) ? offset - 32'd1 : offset;
					emit_token(K_NUMBER, tok_start, len_to(d), 8'd0);
					emit_token(K_DOT, d, 32'd1, 8'd0);
				end
				MODE_IDENT:   emit_token(K_IDENT, tok_start, len_to(offset), 8'd0);
				default: ;
			endcase
			emit_token(K_EOF, offset, 32'd0, 8'd0);
		endfunction

		function void note_byte(logic [7:0] c, logic present, logic eos);
			run_words.delete();
			if (present) begin
				scan_byte(c, offset);
				if (offset != OFFSET_TOP) offset++;
			end
			if (eos) begin
				finish_source();
				restart();
			end
			if (run_words.size() > 0) run_words[run_words.size() - 1].last = 1'b1;
			foreach (run_words[i]) expected_tokens.push_back(run_words[i]);
		endfunction

		task report(string what, logic [31:0] got, logic [31:0] want);
			errors++;
			if (errors <= MAX_PRINTS)
				$display("token word %0d: %s is %0h, expected %0h", words_seen, what, got, want);
		endtask

		task check_word(logic [4:0] kind, logic [71:0] data, logic last);
			token_word_t w;
			words_seen++;
			if (expected_tokens.size() == 0) begin
				report("unexpected word, kind", kind, 32'd0);
				return;
			end
			w = expected_tokens.pop_front();
			if (kind !== w.kind) report("kind", kind, w.kind);
			if (data[31:0] !== w.start) report("start offset", data[31:0], w.start);
			if (data[47:32] !== w.len) report("lexeme length", data[47:32], w.len);
			if (data[63:48] !== w.line) report("line", data[63:48], w.line);
			if (data[71:64] !== w.ech) report("error char", data[71:64], w.ech);
			if (last !== w.last) report("last of run", last, w.last);
		endtask
	endclass

endpackage

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// source_text_lexer_core testbench
// feeds directed and random source texts through the lexer, predicts the
// token words with a scoreboard and checks every word in order, with random
// idling on both sides and one long output stall
// ----------------------------------------------------------------------------
module tb;

	import stl_pkg::*;
	import stl_tb_pkg::*;

	localparam int STALL_LIMIT  = 3000;  // cycles with no word moving on either side
	localparam int DRAIN_CYCLES = 8;
	localparam int RANDOM_ITEMS = 170;
	localparam int LONG_LINES   = 4;     // newlines inside one string
	localparam int NEST_OPENS   = 3;     // nested comment openers
	localparam int NEST_CLOSES  = 2;     // one fewer closer, comment stays open
	localparam int CALM_TAIL    = 40;    // final words sent with no idling
	localparam int HOLD_AT_WORD = 30;
	localparam int HOLD_CYCLES  = 300;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic [0:0]  s_tuser = '0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [71:0] m_tdata;
	logic [4:0]  m_tuser;
	logic        m_tlast;

	src_item_t       src_q[$];
	int              counted = 0;
	int              calm_from = 0;
	bit              calm = 1'b0;
	token_scoreboard sb;

	always #2 clk = ~clk;

	source_text_lexer_core u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// ---------------------------------------------------------------- stimulus

	// words with neither a byte nor an end mark are ignored by the block, so not counted
	task automatic push_item(logic [7:0] c, logic present, logic eos);
		src_item_t it;
		it.code = c;
		it.present = present;
		it.eos = eos;
		src_q.push_back(it);
		if (present || eos) counted++;
	endtask

	task automatic add_byte(logic [7:0] c);
		push_item(c, 1'b1, 1'b0);
	endtask

	task automatic add_text(string s);
		for (int i = 0; i < s.len(); i++) add_byte(s[i]);
	endtask

	// close the source either on its last byte or with a bare end marker
	task automatic end_source(bit bare);
		if (bare || src_q.size() == 0) push_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
		else src_q[$].eos = 1'b1;
	endtask

	function automatic logic [7:0] any_letter();
		case ($urandom_range(0, 2))
			0: return 8'(CH_LA + $urandom_range(0, 25));
			1: return 8'(CH_UA + $urandom_range(0, 25));
			default: return CH_UNDERSCORE;
		endcase
	endfunction

	function automatic logic [7:0] any_digit();
		return 8'(CH_0 + $urandom_range(0, 9));
	endfunction

	function automatic logic [7:0] any_ws();
		case ($urandom_range(0, 3))
			0: return CH_SPACE;
			1: return CH_TAB;
			2: return CH_CR;
			default: return CH_NL;
		endcase
	endfunction

	// printable text for string and comment bodies, no quote, some newlines
	function automatic logic [7:0] any_text();
		logic [7:0] c;
		if ($urandom_range(0, 7) == 0) return CH_NL;
		c = 8'($urandom_range(32, 126));
		return (c == CH_QUOTE) ? CH_UNDERSCORE : c;
	endfunction

	// one well formed lexeme, with a little noise among the choices
	task automatic add_fragment();
		string ops;
		ops = "(){},.-+;*!=^%";
		case ($urandom_range(0, 11))
			0: begin
				add_byte(any_letter());
				repeat ($urandom_range(0, 5))
					add_byte($urandom_range(0, 1) ? any_letter() : any_digit());
			end
			1: repeat ($urandom_range(1, 4)) add_byte(any_digit());
			2: begin
				// number with a fraction
				repeat ($urandom_range(1, 3)) add_byte(any_digit());
				add_byte(CH_DOT);
				repeat ($urandom_range(1, 3)) add_byte(any_digit());
			end
			3: begin
				// number then a dot that no digit follows
				repeat ($urandom_range(1, 3)) add_byte(any_digit());
				add_byte(CH_DOT);
				add_byte($urandom_range(0, 1) ? any_letter() : ops[$urandom_range(0, ops.len() - 1)]);
			end
			4: begin
				add_byte(CH_QUOTE);
				repeat ($urandom_range(0, 6)) add_byte(any_text());
				add_byte(CH_QUOTE);
			end
			5: add_byte(ops[$urandom_range(0, ops.len() - 1)]);
			6: begin
				case ($urandom_range(0, 5))
					0: add_text(":=");
					1: add_text("<=");
					2: add_text(">=");
					3: add_text("/=");
					4: add_byte(CH_LESS);
					default: add_byte(CH_GREATER);
				endcase
			end
			7: add_byte(any_ws());
			8: begin
				add_text("//");
				repeat ($urandom_range(0, 5)) add_byte(any_text());
				add_byte(CH_NL);
			end
			9: begin
				// block comment, sometimes with a nested one inside
				add_text("/*");
				repeat ($urandom_range(0, 4)) add_byte(any_text());
				if ($urandom_range(0, 1)) begin
					add_text("/*");
					repeat ($urandom_range(0, 3)) add_byte(any_text());
					add_text("*/");
				end
				add_text("*/");
			end
			10: add_byte(8'($urandom_range(0, 255)));
			default: add_byte(CH_COLON);
		endcase
	endtask

	task automatic build_stimulus();
		int target;
		// every operator, one and two character forms, pending slash at the end
		add_text("(){},.-+;*!=^%:=<=<>=>/=/");
		end_source(1'b0);
		// empty source: end of file at offset zero
		push_item(8'h00, 1'b0, 1'b1);
		// fraction, number then dot, identifier, lone colon, bad bytes incl. both extremes
		add_text("7.5 3.x _Zz9:@");
		add_byte(8'h00);
		add_byte(8'hFF);
		add_text("\"q\n\"// c\n/* /* */ */ a<");
		end_source(1'b1);
		// number then dot at the end, unterminated string, unterminated comment
		add_text("12.");
		end_source(1'b0);
		add_text("\"open\n");
		end_source(1'b0);
		add_text("/*x*");
		end_source(1'b0);
		// string spanning several lines
		add_byte(CH_QUOTE);
		repeat (LONG_LINES) add_byte(CH_NL);
		add_text("\"a");
		end_source(1'b0);
		// nested comments, one level left open at the end
		repeat (NEST_OPENS) add_text("/*");
		repeat (NEST_CLOSES) add_text("*/");
		add_text("x");
		end_source(1'b0);

		target = counted + RANDOM_ITEMS;
		while (counted < target) begin
			repeat ($urandom_range(1, 10)) begin
				add_fragment();
				if ($urandom_range(0, 1)) add_byte(any_ws());
				if ($urandom_range(0, 9) == 0) push_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
			end
			// sometimes leave a string or a comment open at the end
			case ($urandom_range(0, 9))
				0: begin
					add_byte(CH_QUOTE);
					add_byte(any_text());
				end
				1: add_text("/* /*");
				default: ;
			endcase
			end_source($urandom_range(0, 3) == 0);
		end
		calm_from = src_q.size() - CALM_TAIL;
	endtask

	// ---------------------------------------------------------------- driving

	task automatic drive_source();
		src_item_t it;
		for (int i = 0; i < src_q.size(); i++) begin
			it = src_q[i];
			calm = (i >= calm_from);
			// idle burst before this word
			if (!calm && $urandom_range(0, 5) == 0) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
			end
			s_tvalid <= 1'b1;
			s_tdata <= it.code;
			s_tuser <= it.present;
			s_tlast <= it.eos;
			do @(posedge clk); while (!s_tready);
			sb.note_byte(it.code, it.present, it.eos);
		end
		s_tvalid <= 1'b0;
	endtask

	initial begin
		sb = new();
		build_stimulus();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		drive_source();
		// all source words are in, wait for the last token words
		while (sb.expected_tokens.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0) $display("source_text_lexer_core verification clean");
		else $display("source_text_lexer_core verification failed");
		$finish;
	end

	// token side: check each accepted word, stall in random bursts and once for a
	// long stretch so the output buffer fills and the source side backs up
	initial begin
		int hold;
		bit held;
		hold = 0;
		held = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) sb.check_word(m_tuser, m_tdata, m_tlast);
			if (hold > 0) hold--;
			else if (!held && sb.words_seen >= HOLD_AT_WORD) begin
				hold = HOLD_CYCLES;
				held = 1'b1;
			end else if (!calm && $urandom_range(0, 7) == 0) hold = $urandom_range(1, 7);
			m_tready <= (hold == 0);
		end
	end

	// watchdog: end the run when no word moves on either side for too long
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
			else quiet++;
		end
		$display("source_text_lexer_core verification failed");
		$finish;
	end

endmodule
